>>> design/ecdr_pkg.sv
// Package for the event counter with decimal readout.
// Holds operation codes, FSM and command types, ASCII constants and the BCD step.
// No dependencies; used by ecdr_ctrl, ecdr_dp, the top level and the testbench.
package ecdr_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned BITCNT_W   = $clog2(VALUE_W);
  localparam int unsigned DIGCNT_W   = $clog2(BCD_DIGITS + 1);

  localparam logic [6:0] CH_ZERO    = 7'd48;
  localparam logic [6:0] CH_MINUS   = 7'd45;
  localparam logic [6:0] CH_NEWLINE = 7'd10;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_INC  = 2'd1,
    OP_NEG  = 2'd2,
    OP_STOP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_NEWLINE
  } state_t;

  typedef enum logic [1:0] {
    CS_MINUS,
    CS_DIGIT,
    CS_NEWLINE
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      inc;
    logic      negate;
    logic      prep;
    logic      conv_step;
    logic      digit_shift;
    char_sel_t char_sel;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic last_digit;
    logic negative;
  } status_t;

  // Double-dabble correction: every BCD digit of five or more gets three added
  // before the next shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

>>> design/ecdr_if.sv
// Valid/ready channel interfaces for the event counter with decimal readout.
// Depends on nothing; the top level uses one of each.
interface ecdr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] load_value;

  modport source(output valid, operation, load_value, input ready);
  modport sink(input valid, operation, load_value, output ready);
endinterface

interface ecdr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source(output valid, character, last, input ready);
  modport sink(input valid, character, last, output ready);
endinterface

>>> design/ecdr_ctrl.sv
// Controller FSM: takes events, sequences conversion, digit scan and output words.
// Depends on ecdr_pkg.
module ecdr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  output logic                out_valid,
  input  logic                out_ready,
  input  ecdr_pkg::status_t   stat,
  output ecdr_pkg::cmd_t      cmd
);

  ecdr_pkg::state_t state_r, state_nxt;
  logic             stopped_r, stopped_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ecdr_pkg::ST_IDLE;
      stopped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    stopped_nxt = stopped_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.char_sel = ecdr_pkg::CS_DIGIT;
    unique case (state_r)
      ecdr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // Once stopped, every event is taken and dropped.
        if (in_valid && !stopped_r) begin
          unique case (ecdr_pkg::op_t'(in_operation))
            ecdr_pkg::OP_LOAD: cmd.load = 1'b1;
            ecdr_pkg::OP_INC: begin
              cmd.inc   = 1'b1;
              state_nxt = ecdr_pkg::ST_PREP;
            end
            ecdr_pkg::OP_NEG: begin
              cmd.negate = 1'b1;
              state_nxt  = ecdr_pkg::ST_PREP;
            end
            ecdr_pkg::OP_STOP: stopped_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      ecdr_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ecdr_pkg::ST_CONV;
      end
      ecdr_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          state_nxt = ecdr_pkg::ST_SKIP;
        end
      end
      ecdr_pkg::ST_SKIP: begin
        // Drop leading zeros, but always keep the units digit.
        if (stat.top_zero && !stat.last_digit) begin
          cmd.digit_shift = 1'b1;
        end else if (stat.negative) begin
          state_nxt = ecdr_pkg::ST_SIGN;
        end else begin
          state_nxt = ecdr_pkg::ST_DIGIT;
        end
      end
      ecdr_pkg::ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.char_sel = ecdr_pkg::CS_MINUS;
        if (out_ready) begin
          state_nxt = ecdr_pkg::ST_DIGIT;
        end
      end
      ecdr_pkg::ST_DIGIT: begin
        out_valid    = 1'b1;
        cmd.char_sel = ecdr_pkg::CS_DIGIT;
        if (out_ready) begin
          cmd.digit_shift = 1'b1;
          if (stat.last_digit) begin
            state_nxt = ecdr_pkg::ST_NEWLINE;
          end
        end
      end
      ecdr_pkg::ST_NEWLINE: begin
        out_valid    = 1'b1;
        cmd.char_sel = ecdr_pkg::CS_NEWLINE;
        if (out_ready) begin
          state_nxt = ecdr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ecdr_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> design/ecdr_dp.sv
// Datapath: counter register, bit-serial binary to BCD converter, digit shifter.
// Depends on ecdr_pkg; driven by ecdr_ctrl through cmd_t and status_t.
module ecdr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [ecdr_pkg::VALUE_W-1:0] in_load_value,
  input  ecdr_pkg::cmd_t                      cmd,
  output ecdr_pkg::status_t                   stat,
  output logic [6:0]                          out_character,
  output logic                                out_last
);

  logic [ecdr_pkg::VALUE_W-1:0]  count_r, count_nxt;
  logic [ecdr_pkg::VALUE_W-1:0]  mag_r;
  logic [ecdr_pkg::BCD_W-1:0]    bcd_r;
  logic [ecdr_pkg::BITCNT_W-1:0] bit_cnt_r;
  logic [ecdr_pkg::DIGCNT_W-1:0] dig_cnt_r;
  logic                          neg_r;
  logic [ecdr_pkg::BCD_W-1:0]    bcd_adj;
  logic [3:0]                    top_digit;

  assign bcd_adj   = ecdr_pkg::bcd_adjust(bcd_r);
  assign top_digit = bcd_r[ecdr_pkg::BCD_W-1 -: 4];

  always_comb begin
    count_nxt = count_r;
    if (cmd.load) begin
      count_nxt = in_load_value;
    end else if (cmd.inc) begin
      count_nxt = count_r + 32'd1;
    end else if (cmd.negate) begin
      count_nxt = 32'd0 - count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // The magnitude of the most negative value still fits as an unsigned word.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg_r     <= count_r[ecdr_pkg::VALUE_W-1];
      mag_r     <= count_r[ecdr_pkg::VALUE_W-1] ? (32'd0 - count_r) : count_r;
      bcd_r     <= '0;
      bit_cnt_r <= '0;
      dig_cnt_r <= ecdr_pkg::DIGCNT_W'(ecdr_pkg::BCD_DIGITS);
    end else if (cmd.conv_step) begin
      bcd_r     <= {bcd_adj[ecdr_pkg::BCD_W-2:0], mag_r[ecdr_pkg::VALUE_W-1]};
      mag_r     <= {mag_r[ecdr_pkg::VALUE_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end else if (cmd.digit_shift) begin
      bcd_r     <= {bcd_r[ecdr_pkg::BCD_W-5:0], 4'd0};
      dig_cnt_r <= dig_cnt_r - 1'b1;
    end
  end

  assign stat.conv_last  = (bit_cnt_r == ecdr_pkg::BITCNT_W'(ecdr_pkg::VALUE_W - 1));
  assign stat.top_zero   = (top_digit == 4'd0);
  assign stat.last_digit = (dig_cnt_r == ecdr_pkg::DIGCNT_W'(1));
  assign stat.negative   = neg_r;

  always_comb begin
    out_last = 1'b0;
    unique case (cmd.char_sel)
      ecdr_pkg::CS_MINUS: out_character = ecdr_pkg::CH_MINUS;
      ecdr_pkg::CS_DIGIT: out_character = ecdr_pkg::CH_ZERO + {3'd0, top_digit};
      ecdr_pkg::CS_NEWLINE: begin
        out_character = ecdr_pkg::CH_NEWLINE;
        out_last      = 1'b1;
      end
      default: out_character = ecdr_pkg::CH_NEWLINE;
    endcase
  end

endmodule

>>> design/event_counter_decimal_readout.sv
// Channel    Dir  Payload                       Handshake
// in_ch      in   operation[1:0], load_value[31:0]  valid/ready
// out_ch     out  character[6:0], last          valid/ready
//
// Load and stop are taken while idle and leave the block idle. Increment and negate run setup
// (ST_PREP), double-dabble conversion (ST_CONV) and leading-zero skip (ST_SKIP); each skipped
// zero is one digit word fewer, and a negative result adds a minus word.
// One event is in work at a time; in_ch is ready only while idle, and a stalled out_ch
// holds the block in place.
// Reset (rst_n low, synchronous) clears the counter to zero and the stop flag.
// Depends on ecdr_pkg, ecdr_if, ecdr_ctrl and ecdr_dp.
module event_counter_decimal_readout (
  input logic        clk,
  input logic        rst_n,
  ecdr_in_if.sink    in_ch,
  ecdr_out_if.source out_ch
);

  ecdr_pkg::cmd_t    cmd;
  ecdr_pkg::status_t stat;

  ecdr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ecdr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_load_value (in_ch.load_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a word is still being delivered");

  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.character == ecdr_pkg::CH_NEWLINE))
    else $error("last mark on a word other than newline");

  a_first_not_newline: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !out_ch.last)
    else $error("readout started with the closing newline");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.inc, cmd.negate, cmd.prep, cmd.conv_step, cmd.digit_shift}))
    else $error("conflicting datapath commands");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for event_counter_decimal_readout.
// It predicts the decimal text of every increment and negate and checks each output word.
// Depends on ecdr_pkg, ecdr_if and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 76;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } char_word_t;

  class decimal_readout_sb;
    logic [31:0] count;
    bit          halted;
    char_word_t  text_q[$];
    int          errors;

    function new();
      count  = '0;
      halted = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return text_q.size();
    endfunction

    // Queues the characters of the current count: sign, digits, newline.
    function void spell_count();
      logic [31:0] mag;
      logic [3:0]  digits[$];
      mag = count[31] ? 32'd0 - count : count;
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (count[31]) text_q.push_back('{ecdr_pkg::CH_MINUS, 1'b0});
      foreach (digits[i]) text_q.push_back('{ecdr_pkg::CH_ZERO + 7'(digits[i]), 1'b0});
      text_q.push_back('{ecdr_pkg::CH_NEWLINE, 1'b1});
    endfunction

    function void note_event(ecdr_pkg::op_t op, logic [31:0] value);
      if (halted) return;
      case (op)
        ecdr_pkg::OP_LOAD: count = value;
        ecdr_pkg::OP_INC: begin
          count = count + 32'd1;
          spell_count();
        end
        ecdr_pkg::OP_NEG: begin
          count = 32'd0 - count;
          spell_count();
        end
        default: halted = 1'b1;
      endcase
    endfunction

    function void check_char(logic [6:0] ch, logic last);
      char_word_t exp_w;
      if (text_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: unexpected word char=%0d last=%0b", ch, last);
        return;
      end
      exp_w = text_q.pop_front();
      if (ch !== exp_w.ch || last !== exp_w.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                   exp_w.ch, exp_w.last, ch, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left = 0;
  bit   hold_req = 1'b0;

  decimal_readout_sb sb = new();

  ecdr_in_if  in_ch();
  ecdr_out_if out_ch();

  event_counter_decimal_readout dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_char(out_ch.character, out_ch.last);
  end

  // Offers one word and returns at the edge where it is accepted.
  task automatic send_event(ecdr_pkg::op_t op, logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.load_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(op, value);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(20));
      2: return 32'd0 - 32'($urandom_range(20));
      3: return 32'h7FFF_FFFF - 32'($urandom_range(3));
      4: return 32'h8000_0000 + 32'($urandom_range(3));
      default: return 32'($urandom_range(2000000000));
    endcase
  endfunction

  task automatic run_random(int n);
    int r;
    ecdr_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        op = ecdr_pkg::OP_LOAD;
      end else if (r < 65) begin
        op = ecdr_pkg::OP_INC;
      end else begin
        op = ecdr_pkg::OP_NEG;
      end
      send_event(op, (op == ecdr_pkg::OP_LOAD) ? pick_value() : $urandom);
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.operation  = ecdr_pkg::OP_LOAD;
    in_ch.load_value = '0;
    rst_n            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Small values, zero, the wrap at the top and the most negative value.
    send_event(ecdr_pkg::OP_INC, 32'hFFFF_FFFF);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'h7FFF_FFFF);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'hFFFF_FFFF);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'h8000_0000);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'h0);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'd999999999);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'h7FFF_FFFE);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    wait_drained();

    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 52;
    run_random(PHASE_ITEMS);
    wait_drained();

    // The receiver holds off while words keep coming, so the block stalls its input.
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    hold_req       = 1'b1;
    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 7;
    recv_stall_pct = 7;
    run_random(PHASE_ITEMS);
    wait_drained();

    // After a stop every event is ignored, loads and a second stop included.
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_STOP, 32'h0);
    send_event(ecdr_pkg::OP_LOAD, 32'h1234_5678);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    send_event(ecdr_pkg::OP_NEG, 32'h0);
    send_event(ecdr_pkg::OP_STOP, 32'h0);
    send_event(ecdr_pkg::OP_INC, 32'h0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> files.f
design/ecdr_pkg.sv
design/ecdr_if.sv
design/ecdr_ctrl.sv
design/ecdr_dp.sv
design/event_counter_decimal_readout.sv
tb/tb_top.sv
